// File: design/oleg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oleg_pkg
// Shared types and constants for the output-layer error gradient block.
// ----------------------------------------------------------------------------
package oleg_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_LOSS_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACT_MODE  = 1'b1;

  localparam logic [16:0] ONE_Q15 = 17'd32768;

  typedef struct packed {
    logic [15:0] activation;
    logic [15:0] target;
    logic        in_last;
  } in_item_t;

  typedef struct packed {
    logic signed [16:0] gradient;
    logic               out_last;
  } out_item_t;

  // Clamp a Q1.15 value to at most 1.0.
  function automatic logic [15:0] clamp_unit(input logic [15:0] v);
    clamp_unit = (v > 16'd32768) ? 16'd32768 : v;
  endfunction

endpackage

// File: design/oleg_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oleg_buf
// Element buffer: one synchronous memory holding activation and target.
// ----------------------------------------------------------------------------
module oleg_buf import oleg_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF,
  parameter int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [MAX_LEN];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/oleg_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oleg_calc
// Per-element error arithmetic: a staged product chain and a serial divider.
// ----------------------------------------------------------------------------
module oleg_calc import oleg_pkg::*; #(
  parameter int CW = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [15:0]        act,
  input  logic [15:0]        tgt,
  input  logic [CW-1:0]      n,
  input  logic signed [39:0] wsum,
  input  logic               loss_mode,
  input  logic               act_mode,
  output logic               done,
  output logic signed [16:0] grad
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_M1   = 3'd1;
  localparam logic [2:0] S_M2   = 3'd2;
  localparam logic [2:0] S_M3   = 3'd3;
  localparam logic [2:0] S_M4   = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;
  localparam int QW = 64;          // magnitude width of the Q.45 product
  localparam int DW = CW + 30;     // divisor width
  localparam int KW = $clog2(QW + 1);

  logic [2:0]         st_r, st_nxt;
  logic signed [17:0] p_r;         // a-y or a-1, signed
  logic signed [35:0] m_r;         // Q.30 intermediate
  logic signed [40:0] d_r;         // S - a(a-y)
  logic signed [QW:0] prod_r;
  logic [QW-1:0]      quo_r, rem_r;
  logic               neg_r;
  logic [KW-1:0]      k_r;
  logic signed [16:0] grad_r;
  logic [DW-1:0]      divisor;
  logic [QW:0]        trial;
  logic signed [17:0] ae, ye;
  logic signed [QW:0] res_full;
  logic signed [17:0] one_m_a;
  logic signed [35:0] yp, ap, aa;
  logic signed [58:0] ad;
  logic signed [53:0] mp;

  assign ae = 18'(act);
  assign ye = 18'(tgt);
  assign divisor = {n, 30'd0};
  assign trial = {rem_r, quo_r[QW-1]} - {{(QW+1-DW){1'b0}}, divisor};

  // Full-width products for the datapath steps
  assign one_m_a = 18'sd32768 - ae;
  assign yp = ye * p_r;
  assign ap = ae * p_r;
  assign aa = ae * one_m_a;
  assign ad = ae * d_r;
  assign mp = m_r * p_r;

  function automatic logic signed [16:0] sat(input logic signed [QW:0] v);
    if (v > 65535) sat = 17'sd65535;
    else if (v < -65536) sat = -17'sd65536;
    else sat = v[16:0];
  endfunction

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (start) st_nxt = S_M1;
      S_M1:   st_nxt = S_M2;
      S_M2:   st_nxt = S_M3;
      S_M3:   st_nxt = S_M4;
      S_M4:   st_nxt = (loss_mode) ? S_DONE : S_DIV;
      S_DIV:  if (k_r == KW'(QW)) st_nxt = S_DONE;
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign res_full = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        k_r <= '0;
      end
      S_M1: begin
        // a-y for quadratic and softmax, a-1 for cross-entropy sigmoid
        p_r <= (loss_mode && !act_mode) ? ae - 18'sd32768 : ae - ye;
      end
      S_M2: begin
        if (loss_mode) m_r <= yp;
        else if (act_mode) m_r <= ap;
        else m_r <= aa;
      end
      S_M3: begin
        if (loss_mode) begin
          if (act_mode) grad_r <= sat((QW+1)'(ye - ae));
          else begin
            m_r <= (m_r < 0) ? -((-m_r) >>> 15) : (m_r >>> 15);
          end
        end else if (act_mode) d_r <= 41'(wsum) - 41'(m_r);
        else m_r <= 36'(m_r >>> 0);
      end
      S_M4: begin
        if (loss_mode) begin
          if (!act_mode) grad_r <= sat((QW+1)'(m_r));
        end else begin
          if (act_mode) prod_r <= (QW+1)'(ad);
          else prod_r <= (QW+1)'(mp);
        end
        k_r <= '0;
      end
      S_DIV: begin
        if (k_r == '0) begin
          neg_r <= prod_r < 0;
          quo_r <= (prod_r < 0) ? QW'(-prod_r) : QW'(prod_r);
          rem_r <= '0;
          k_r   <= KW'(1);
        end else begin
          if (!trial[QW]) begin
            rem_r <= trial[QW-1:0];
            quo_r <= {quo_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[QW-2:0], quo_r[QW-1]};
            quo_r <= {quo_r[QW-2:0], 1'b0};
          end
          k_r <= k_r + KW'(1);
        end
      end
      S_DONE: begin
        if (!loss_mode) grad_r <= sat(res_full);
      end
      default: ;
    endcase
  end

  assign done = (st_r == S_DONE);
  assign grad = (st_r == S_DONE && !loss_mode) ? sat(res_full) : grad_r;

endmodule

// File: design/output_layer_error_gradient.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// output_layer_error_gradient
// Output-layer error gradient over one buffered vector.
// ----------------------------------------------------------------------------
// Elements load at one per cycle into a single-port-write memory while the
// weighted sum S = sum a(a-y) accumulates. On the element flagged last the
// block stops taking input and emits N error values in arrival order. Each
// emitted value goes through a memory read and a shared arithmetic unit;
// quadratic modes add a 64-step bit-serial division by N*2^30, and the result
// side can stall. Elements beyond MAX_LEN are dropped (a last one still
// triggers emission).
module output_layer_error_gradient import oleg_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  localparam logic [1:0] P_LOAD = 2'd0;
  localparam logic [1:0] P_READ = 2'd1;
  localparam logic [1:0] P_CALC = 2'd2;
  localparam logic [1:0] P_OUT  = 2'd3;

  logic [1:0]         ph_r;
  logic               loss_r, act_r;
  logic [CW-1:0]      cnt_r, idx_r;
  logic signed [39:0] sum_r;
  logic               out_valid_r;
  out_item_t          out_r;
  logic               in_fire, store, calc_start, calc_done;
  logic [15:0]        a_c, y_c;
  logic [31:0]        rd_data;
  logic signed [16:0] grad;
  logic [AW-1:0]      rd_addr;
  logic signed [16:0] a_s, ay_s;
  logic signed [33:0] aay;

  assign in_stall = (ph_r != P_LOAD);
  assign in_fire  = in_valid && !in_stall;
  assign a_c = clamp_unit(in_data.activation);
  assign y_c = clamp_unit(in_data.target);
  assign store = in_fire && (cnt_r < CW'(MAX_LEN));
  assign rd_addr = idx_r[AW-1:0];

  // a(a-y) of the incoming element, exact in Q.30
  assign a_s  = $signed({1'b0, a_c});
  assign ay_s = a_s - $signed({1'b0, y_c});
  assign aay  = a_s * ay_s;

  oleg_buf #(.MAX_LEN(MAX_LEN), .AW(AW)) u_buf (
    .clk(clk), .wr_en(store), .wr_addr(cnt_r[AW-1:0]),
    .wr_data({a_c, y_c}), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign calc_start = (ph_r == P_READ);

  oleg_calc #(.CW(CW)) u_calc (
    .clk(clk), .rst_n(rst_n), .start(calc_start),
    .act(rd_data[31:16]), .tgt(rd_data[15:0]), .n(cnt_r), .wsum(sum_r),
    .loss_mode(loss_r), .act_mode(act_r), .done(calc_done), .grad(grad)
  );

  // Hold configuration; writes must arrive only while idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loss_r <= 1'b0;
      act_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOSS_MODE: loss_r <= cfg_data[0];
        REG_ACT_MODE:  act_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= P_LOAD;
      cnt_r       <= '0;
      idx_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (ph_r)
        P_LOAD: begin
          if (store) begin
            cnt_r <= cnt_r + CW'(1);
            sum_r <= sum_r + 40'(aay);
          end
          if (in_fire && in_data.in_last) begin
            idx_r <= '0;
            ph_r  <= P_READ;
          end
        end
        P_READ: ph_r <= P_CALC;   // memory data lands; start the unit
        P_CALC: begin
          if (calc_done) begin
            out_r.gradient <= grad;
            out_r.out_last <= (idx_r + CW'(1) == cnt_r);
            out_valid_r    <= 1'b1;
            ph_r           <= P_OUT;
          end
        end
        P_OUT: begin
          // Advance on the result transfer; return to load after the last.
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (out_r.out_last) begin
              cnt_r <= '0;
              sum_r <= '0;
              ph_r  <= P_LOAD;
            end else begin
              idx_r <= idx_r + CW'(1);
              ph_r  <= P_READ;
            end
          end
        end
        default: ph_r <= P_LOAD;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_LEN)) else $error("count beyond depth");
  a_valid_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ph_r == P_OUT) else $error("result outside output phase");
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r != P_LOAD |-> idx_r < cnt_r) else $error("index past count");
  a_reset_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.out_last |=> cnt_r == '0)
    else $error("count not cleared");
`endif

endmodule

// File: verif/tb_output_layer_error_gradient.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_output_layer_error_gradient
// Self-checking bench for the output-layer error gradient block.
// ----------------------------------------------------------------------------
// An initial block queues whole vectors phase by phase and sets the loss and
// activation registers while the block is idle between phases (once also
// mid-vector). A falling-edge driver presents the queued elements with random
// gaps. A rising-edge monitor predicts the error values of each vector on the
// transfer of its last element and compares every result transfer with the
// oldest prediction. The result side stalls at random.
// ----------------------------------------------------------------------------
module tb_output_layer_error_gradient;
  import oleg_pkg::*;

  localparam int          DEPTH       = MAX_LEN_DEF;
  localparam int          CYCLE_LIMIT = 600000;
  localparam logic [16:0] UNIT        = 17'd32768;
  localparam longint      GRAD_HI     = 65535;
  localparam longint      GRAD_LO     = -65536;

  // register values, named by meaning
  localparam logic LOSS_QUAD    = 1'b0;
  localparam logic LOSS_XENT    = 1'b1;
  localparam logic ACT_SIGMOID  = 1'b0;
  localparam logic ACT_SOFTMAX  = 1'b1;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  output_layer_error_gradient #(.MAX_LEN(DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns period
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // --- bench state ---------------------------------------------------------
  in_item_t  element_queue[$];     // elements waiting for the driver
  out_item_t gradient_queue[$];    // predicted error values, oldest first
  logic      loss_sel, act_sel;    // mirror of the registers
  logic [15:0] held_act[DEPTH];
  logic [15:0] held_tgt[DEPTH];
  int        held_count;
  longint    act_err_sum;          // S = sum a(a-y), Q.30
  logic      quiet;                // no idling on either side
  logic      in_took;              // an input transfer happened at the last edge
  int        send_gap, recv_gap;
  int        fail_count, vector_count, result_count, element_count;
  int        cycle_count;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint limit_unit(logic [15:0] v);
    return (v > 16'd32768) ? longint'(UNIT) : longint'(v);
  endfunction

  // Error value for one buffered element of an N-element vector.
  function automatic logic signed [16:0] error_value(longint a, longint y, longint n);
    longint v;
    longint scale;
    scale = n * (longint'(1) << 30);
    if (loss_sel == LOSS_QUAD) begin
      if (act_sel == ACT_SIGMOID) v = (a * (longint'(UNIT) - a) * (a - y)) / scale;
      else                        v = (a * (act_err_sum - a * (a - y))) / scale;
    end else begin
      if (act_sel == ACT_SIGMOID) v = (y * (a - longint'(UNIT))) / longint'(UNIT);
      else                        v = y - a;
    end
    if (v > GRAD_HI) v = GRAD_HI;
    if (v < GRAD_LO) v = GRAD_LO;
    return v[16:0];
  endfunction

  // Buffer one transferred element; on the last one queue the vector's errors.
  task automatic absorb_element(in_item_t it);
    longint    a, y;
    out_item_t res;
    a = limit_unit(it.activation);
    y = limit_unit(it.target);
    element_count++;
    if (held_count < DEPTH) begin
      held_act[held_count] = a[15:0];
      held_tgt[held_count] = y[15:0];
      act_err_sum += a * (a - y);
      held_count++;
    end
    if (it.in_last) begin
      for (int k = 0; k < held_count; k++) begin
        res.gradient = error_value(longint'(held_act[k]), longint'(held_tgt[k]),
                                   longint'(held_count));
        res.out_last = (k + 1 == held_count);
        gradient_queue.push_back(res);
      end
      held_count  = 0;
      act_err_sum = 0;
      vector_count++;
    end
  endtask

  // --- monitor: inputs first, then results, at the rising edge ------------
  always @(posedge clk) begin
    out_item_t want;
    logic      took;
    took = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        took = 1'b1;
        absorb_element(in_data);
      end
      if (out_valid && !out_stall) begin
        result_count++;
        if (gradient_queue.size() == 0) begin
          $display("%0t: unexpected result gradient=%0d last=%0b", $time,
                   $signed(out_data.gradient), out_data.out_last);
          fail_count++;
        end else begin
          want = gradient_queue.pop_front();
          if (out_data.gradient !== want.gradient) begin
            $display("%0t: gradient mismatch expected %0d actual %0d", $time,
                     $signed(want.gradient), $signed(out_data.gradient));
            fail_count++;
          end
          if (out_data.out_last !== want.out_last) begin
            $display("%0t: out_last mismatch expected %0b actual %0b", $time,
                     want.out_last, out_data.out_last);
            fail_count++;
          end
        end
      end
    end
    in_took <= took;
  end

  // --- driver: advance the element queue at the falling edge --------------
  always @(negedge clk) begin
    logic     nxt_valid;
    in_item_t nxt_data;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    if (rst_n && !(in_valid && !in_took)) begin
      // previous element transferred (or none held): drop it, maybe send next
      nxt_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
      end else if (element_queue.size() > 0) begin
        nxt_data  = element_queue.pop_front();
        nxt_valid = 1'b1;
        send_gap  = pick_gap();
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // --- result-side stall ---------------------------------------------------
  always @(negedge clk) begin
    if (recv_gap > 0) begin
      recv_gap  = recv_gap - 1;
      out_stall <= 1'b1;
    end else begin
      recv_gap  = pick_gap();
      out_stall <= (recv_gap > 0);
    end
  end

  // --- watchdog ------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               gradient_queue.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // --- stimulus helpers ----------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Wait until the block has drained, then let it settle.
  task automatic wait_idle();
    while (element_queue.size() > 0 || in_valid || gradient_queue.size() > 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_modes(logic loss, logic act);
    wait_idle();
    write_reg(REG_LOSS_MODE, loss);
    write_reg(REG_ACT_MODE, act);
    loss_sel = loss;
    act_sel  = act;
  endtask

  function automatic logic [15:0] rand_q15();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'd32768;
    if (r == 2) return 16'($urandom_range(0, 65535));   // may exceed 1.0
    return 16'($urandom_range(0, 32768));
  endfunction

  task automatic push_element(logic [15:0] a, logic [15:0] y, logic last);
    in_item_t it;
    it.activation = a;
    it.target     = y;
    it.in_last    = last;
    element_queue.push_back(it);
  endtask

  task automatic push_vector(int len);
    for (int i = 0; i < len; i++) push_element(rand_q15(), rand_q15(), i == len - 1);
  endtask

  int len;

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    loss_sel = LOSS_QUAD; act_sel = ACT_SIGMOID;
    held_count = 0; act_err_sum = 0; quiet = 1'b0; in_took = 1'b0;
    send_gap = 0; recv_gap = 0; fail_count = 0; vector_count = 0;
    result_count = 0; element_count = 0; cycle_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset modes, extremes and over-range values, single element.
    push_element(16'd32768, 16'd0, 1'b0);
    push_element(16'd0, 16'd32768, 1'b0);
    push_element(16'hFFFF, 16'h8001, 1'b0);
    push_element(16'd16384, 16'd32768, 1'b1);
    push_element(16'd32768, 16'd32768, 1'b1);
    set_modes(LOSS_QUAD, ACT_SOFTMAX);
    push_element(16'd32768, 16'd0, 1'b0);
    push_element(16'd1, 16'hFFFF, 1'b0);
    push_element(16'hFFFF, 16'd0, 1'b1);
    set_modes(LOSS_XENT, ACT_SIGMOID);
    push_element(16'd0, 16'd32768, 1'b0);
    push_element(16'hFFFF, 16'hFFFF, 1'b0);
    push_element(16'd0, 16'd0, 1'b1);
    set_modes(LOSS_XENT, ACT_SOFTMAX);
    push_element(16'd0, 16'd32768, 1'b0);
    push_element(16'd32768, 16'd0, 1'b0);
    push_element(16'h7FFF, 16'hFFFF, 1'b1);

    // Random phases; each ends with the sender held until all results are in.
    for (int ph = 0; ph < 14; ph++) begin
      set_modes(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      quiet = (ph % 5 == 2);
      for (int v = 0; v < 5; v++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        push_vector(len);
      end
    end

    // Buffer full: last lands exactly after a full buffer, then overflow.
    set_modes(LOSS_QUAD, ACT_SOFTMAX);
    push_vector(DEPTH + 1);
    set_modes(LOSS_XENT, ACT_SIGMOID);
    push_vector(DEPTH + 4);

    // Mode change while a vector is partly loaded.
    push_vector(2);
    wait_idle();
    push_element(rand_q15(), rand_q15(), 1'b0);
    push_element(rand_q15(), rand_q15(), 1'b0);
    wait_idle();
    write_reg(REG_LOSS_MODE, LOSS_QUAD);
    write_reg(REG_ACT_MODE, ACT_SIGMOID);
    loss_sel = LOSS_QUAD;
    act_sel  = ACT_SIGMOID;
    push_element(rand_q15(), rand_q15(), 1'b1);

    wait_idle();
    $display("Covered %0d vectors, %0d elements, %0d error values in all four modes,",
             vector_count, element_count, result_count);
    $display("including over-range inputs, full-buffer drops and mid-vector mode writes.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
